// ===== src/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the spike cross-correlogram block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int TIME_W  = 31;
    localparam int WIDTH_W = 16;
    localparam int COUNT_W = 21;
    localparam int IDX_W   = 6;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD_REF = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_TGT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_REF_RD,
        ST_REF_WAIT,
        ST_TGT_RD,
        ST_TGT_WAIT,
        ST_DIV,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

endpackage

// ===== src/spike_cross_correlogram.sv =====
`timescale 1ns / 1ps
// Compute clears every bin, then per reference spike scans its targets: one
// before the window is skipped, one at or past its end ends the scan, others
// are binned by a restoring divide. Emission sends the bins in order, held by
// i_ready. Not ready until the last bin is taken. Sync active-low reset clears
// spike counts, bin_width (to 1), control; memories kept.
// ----------------------------------------------------------------------------
// spike_cross_correlogram
// Cross-correlation histogram of two ascending spike time lists.
// ----------------------------------------------------------------------------
module spike_cross_correlogram
    import scc_pkg::*;
#(
    parameter int BINS       = 64,
    parameter int MAX_SPIKES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WIDTH_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [TIME_W-1:0]  i_spike_time,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IDX_W-1:0]   o_bin_index,
    output logic [COUNT_W-1:0] o_bin_count,
    output logic               o_last_bin
);

    localparam int AW  = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
    localparam int CW  = $clog2(MAX_SPIKES + 1);
    localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int DW  = TIME_W + 2;              // signed difference width
    localparam int SPW = WIDTH_W + BW + 1;        // span width
    localparam int DCW = $clog2(WIDTH_W + 1);
    localparam logic [BW-1:0]  LAST_BIN = BW'(BINS - 1);
    localparam logic [BW:0]    BINS_V   = (BW + 1)'(BINS);

    t_state r_state, n_state;

    logic [WIDTH_W-1:0] r_width;
    logic [CW-1:0]      r_ref_cnt, r_tgt_cnt;
    logic [CW-1:0]      r_ir, r_it, r_scan0;
    logic [BW-1:0]      r_bin;

    logic [TIME_W-1:0]  r_ref_mem [MAX_SPIKES];
    logic [TIME_W-1:0]  r_tgt_mem [MAX_SPIKES];
    logic [COUNT_W-1:0] r_hist    [BINS];
    logic [TIME_W-1:0]  r_ref_rd, r_tgt_rd;
    logic [COUNT_W-1:0] r_hist_rd;

    logic signed [DW-1:0] r_rem;      // dividend / remainder
    logic [DW-1:0]        r_quo;
    logic [DCW-1:0]       r_dcnt;

    logic [IDX_W-1:0]   r_o_idx;
    logic [COUNT_W-1:0] r_o_cnt;
    logic               r_o_last, r_o_valid;

    logic [WIDTH_W-1:0]   w_eff;
    logic [SPW-1:0]       w_span;
    logic signed [DW-1:0] w_start, w_diff, w_off;
    logic [DW-1:0]        w_trial;
    logic                 w_in_acc;

    assign w_eff   = (r_width == '0) ? WIDTH_W'(1) : r_width;
    assign w_span  = (SPW'(w_eff) * SPW'(BINS) - SPW'(1)) >> 1;
    assign w_start = -$signed(DW'(w_span));
    assign w_diff  = $signed({2'b00, r_tgt_rd}) - $signed({2'b00, r_ref_rd});
    assign w_off   = w_diff - w_start;
    assign w_in_acc = i_valid && o_ready;
    // restoring step, one quotient bit per cycle; the quotient is below BINS
    assign w_trial = DW'(r_rem) - (DW'(w_eff) << (r_dcnt - DCW'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_in_acc && i_op == OP_COMPUTE) n_state = ST_CLEAR;
            ST_CLEAR:    if (r_bin == LAST_BIN) n_state = ST_REF_RD;
            ST_REF_RD:   n_state = (r_ir < r_ref_cnt) ? ST_REF_WAIT : ST_EMIT_RD;
            ST_REF_WAIT: n_state = ST_TGT_RD;
            ST_TGT_RD:   n_state = (r_it < r_tgt_cnt) ? ST_TGT_WAIT : ST_REF_RD;
            ST_TGT_WAIT: n_state = (w_diff < w_start) ? ST_TGT_RD : ST_DIV;
            ST_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = (r_quo >= DW'(BINS)) ? ST_REF_RD : ST_HIST_RD;
                end
            end
            ST_HIST_RD:  n_state = ST_HIST_WR;
            ST_HIST_WR:  n_state = ST_TGT_RD;
            ST_EMIT_RD:  if (!r_o_valid || i_ready) n_state = ST_EMIT;
            ST_EMIT:     n_state = (r_bin == LAST_BIN) ? ST_IDLE : ST_EMIT_RD;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE) && !r_o_valid;
    end

    // a target at or past the window end skips the divide and ends the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_width   <= WIDTH_W'(1);
            r_ref_cnt <= '0;
            r_tgt_cnt <= '0;
            r_o_valid <= 1'b0;
            r_ir <= '0; r_it <= '0; r_scan0 <= '0; r_bin <= '0; r_dcnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_width <= i_cfg_data;
            if (r_o_valid && i_ready) r_o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_bin <= '0; r_ir <= '0; r_scan0 <= '0;
                    if (w_in_acc && i_op == OP_LOAD_REF && r_ref_cnt < CW'(MAX_SPIKES))
                        r_ref_cnt <= r_ref_cnt + CW'(1);
                    if (w_in_acc && i_op == OP_LOAD_TGT && r_tgt_cnt < CW'(MAX_SPIKES))
                        r_tgt_cnt <= r_tgt_cnt + CW'(1);
                end
                ST_CLEAR: r_bin <= r_bin + BW'(1);
                ST_REF_RD: begin
                    r_it <= r_scan0;
                    r_bin <= '0;
                end
                ST_REF_WAIT: r_ir <= r_ir + CW'(1);
                ST_TGT_WAIT: begin
                    if (w_diff < w_start) begin
                        r_scan0 <= r_scan0 + CW'(1);
                        r_it    <= r_it + CW'(1);
                    end else if (DW'(w_off) >= DW'(BINS_V) * DW'(w_eff)) begin
                        r_dcnt <= '0;   // beyond window
                    end else begin
                        r_dcnt <= DCW'(BW + 1);
                    end
                end
                ST_DIV: begin
                    if (r_dcnt != '0) r_dcnt <= r_dcnt - DCW'(1);
                    else r_bin <= r_quo[BW-1:0];
                end
                ST_HIST_WR: r_it <= r_it + CW'(1);
                ST_EMIT: begin
                    r_o_valid <= 1'b1;
                    r_bin <= r_bin + BW'(1);
                    if (r_bin == LAST_BIN) begin
                        r_ref_cnt <= '0;
                        r_tgt_cnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: memories, divider, histogram
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_op == OP_LOAD_REF && r_ref_cnt < CW'(MAX_SPIKES))
            r_ref_mem[r_ref_cnt[AW-1:0]] <= i_spike_time;
        if (w_in_acc && i_op == OP_LOAD_TGT && r_tgt_cnt < CW'(MAX_SPIKES))
            r_tgt_mem[r_tgt_cnt[AW-1:0]] <= i_spike_time;
        // reference time is held for the whole scan of its targets
        if (r_state == ST_REF_RD) r_ref_rd <= r_ref_mem[r_ir[AW-1:0]];
        r_tgt_rd  <= r_tgt_mem[r_it[AW-1:0]];
        r_hist_rd <= r_hist[r_bin];
        case (r_state)
            ST_CLEAR: r_hist[r_bin] <= '0;
            ST_TGT_WAIT: begin
                r_rem <= w_off;
                r_quo <= (DW'(w_off) >= DW'(BINS_V) * DW'(w_eff)) ? DW'(BINS) : '0;
            end
            ST_DIV: begin
                if (r_dcnt != '0) begin
                    if (!w_trial[DW-1] && DW'(r_rem) >= (DW'(w_eff) << (r_dcnt - DCW'(1)))) begin
                        r_rem <= $signed(w_trial);
                        r_quo <= r_quo | (DW'(1) << (r_dcnt - DCW'(1)));
                    end
                end
            end
            ST_HIST_WR:
                if (r_hist_rd != COUNT_MAX) r_hist[r_bin] <= r_hist_rd + COUNT_W'(1);
            ST_EMIT: begin
                r_o_idx  <= IDX_W'(r_bin);
                r_o_cnt  <= r_hist_rd;
                r_o_last <= (r_bin == LAST_BIN);
            end
            default: ;
        endcase
    end

    assign o_valid     = r_o_valid;
    assign o_bin_index = r_o_idx;
    assign o_bin_count = r_o_cnt;
    assign o_last_bin  = r_o_last;

endmodule
